[sv/sprd_pkg.sv]
// ============================================================================
// sprd_pkg: shared types and constants of the space packet deframer
// Field widths, register indexes, queue sizing and the queue entry layout.
// ============================================================================
package sprd_pkg;

    localparam int HDR_BYTES   = 6;
    localparam int PKT_LIMIT   = 4096;
    localparam int QUEUE_DEPTH = 8;

    localparam int BYTE_W  = 8;
    localparam int IDENT_W = 16;
    localparam int TOTAL_W = 13;
    localparam int DROP_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int HCNT_W  = $clog2(HDR_BYTES);
    localparam int FILL_W  = $clog2(HDR_BYTES);

    localparam logic [CFG_IDX_W-1:0] REG_ID_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd4;

    localparam logic [IDENT_W-1:0] ID_A_RESET    = 16'h089C;
    localparam logic [IDENT_W-1:0] ID_B_RESET    = 16'h089D;
    localparam logic [IDENT_W-1:0] ID_C_RESET    = 16'h089E;
    localparam logic [IDENT_W-1:0] ID_D_RESET    = 16'h089F;
    localparam logic [TOTAL_W-1:0] MAX_LEN_RESET = 13'd512;
    localparam logic [TOTAL_W-1:0] LIMIT_CAP     = TOTAL_W'(PKT_LIMIT);
    localparam logic [16:0]        HDR_PLUS_ONE  = 17'(HDR_BYTES + 1);

    typedef enum logic {
        MODE_HUNT,
        MODE_PAYLOAD
    } front_mode_t;

    typedef struct packed {
        logic                                is_header;
        logic [HDR_BYTES-1:0][BYTE_W-1:0]    bytes;
        logic                                last;
        logic [IDENT_W-1:0]                  ident;
        logic [TOTAL_W-1:0]                  total;
        logic [DROP_W-1:0]                   dropped;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[sv/sprd_if.sv]
// ============================================================================
// sprd_if: byte channels of the space packet deframer
// Receive channel carrying raw link bytes and transmit channel carrying
// packet bytes with their framing flags and packet information.
// ============================================================================
interface sprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sprd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        first_flag;
    logic        last_flag;
    logic [15:0] packet_ident;
    logic [12:0] packet_total;
    logic [31:0] resync_total;

    modport source (output valid, output out_byte, output first_flag, output last_flag,
                    output packet_ident, output packet_total, output resync_total,
                    input ready);
    modport sink (input valid, input out_byte, input first_flag, input last_flag,
                  input packet_ident, input packet_total, input resync_total,
                  output ready);
endinterface

[sv/sprd_front.sv]
// ============================================================================
// sprd_front: header hunting and classification
// Holds the configuration registers and the sliding header window, checks
// each completed window and queues one entry per header or payload byte.
// ============================================================================
module sprd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sprd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sprd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    sprd_in_if.sink                         rx,
    input  sprd_pkg::queue_status_t         q_status,
    output logic                            q_push,
    output sprd_pkg::queue_entry_t          q_entry
);
    import sprd_pkg::*;

    logic [IDENT_W-1:0] id_a_reg, id_b_reg, id_c_reg, id_d_reg;
    logic [TOTAL_W-1:0] max_len_reg;

    front_mode_t        mode_reg, mode_next;
    logic [BYTE_W-1:0]  window_reg [HDR_BYTES-1];
    logic [BYTE_W-1:0]  window_next [HDR_BYTES-1];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TOTAL_W-1:0] remain_reg, remain_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [DROP_W-1:0]  dropped_reg, dropped_next;

    logic               accept;
    logic               window_full;
    logic [IDENT_W-1:0] cand_id;
    logic [15:0]        cand_len;
    logic [16:0]        cand_total;
    logic [TOTAL_W-1:0] limit;
    logic               id_hit;
    logic               hdr_ok;
    logic [TOTAL_W-1:0] remain_dec;
    logic               pay_last;

    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_a_reg    <= ID_A_RESET;
            id_b_reg    <= ID_B_RESET;
            id_c_reg    <= ID_C_RESET;
            id_d_reg    <= ID_D_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ID_A:    id_a_reg    <= cfg_wdata;
                REG_ID_B:    id_b_reg    <= cfg_wdata;
                REG_ID_C:    id_c_reg    <= cfg_wdata;
                REG_ID_D:    id_d_reg    <= cfg_wdata;
                REG_MAX_LEN: max_len_reg <= cfg_wdata[TOTAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        window_full = (fill_reg == FILL_W'(HDR_BYTES - 1));
        cand_id     = {window_reg[0], window_reg[1]};
        cand_len    = {window_reg[HDR_BYTES-2], rx.rx_byte};
        cand_total  = {1'b0, cand_len} + HDR_PLUS_ONE;
        limit       = (max_len_reg > LIMIT_CAP) ? LIMIT_CAP : max_len_reg;
        id_hit      = (cand_id == id_a_reg) || (cand_id == id_b_reg) ||
                      (cand_id == id_c_reg) || (cand_id == id_d_reg);
        hdr_ok      = window_full && id_hit && (cand_total <= {4'b0, limit});
        remain_dec  = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
        pay_last    = (remain_dec == '0);
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_HUNT:    mode_next = hdr_ok ? MODE_PAYLOAD : MODE_HUNT;
                MODE_PAYLOAD: mode_next = pay_last ? MODE_HUNT : MODE_PAYLOAD;
                default:      mode_next = MODE_HUNT;
            endcase
        end
    end

    always_comb
    begin
        window_next  = window_reg;
        fill_next    = fill_reg;
        remain_next  = remain_reg;
        ident_next   = ident_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        q_push       = 1'b0;
        q_entry      = '0;
        q_entry.ident   = ident_reg;
        q_entry.total   = total_reg;
        q_entry.dropped = dropped_reg;
        q_entry.bytes[0] = rx.rx_byte;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_PAYLOAD:
                begin
                    remain_next  = remain_dec;
                    q_push       = 1'b1;
                    q_entry.last = pay_last;
                    if (pay_last)
                    begin
                        fill_next = '0;
                    end
                end
                default:
                begin
                    if (!window_full)
                    begin
                        window_next[fill_reg] = rx.rx_byte;
                        fill_next = fill_reg + 1'b1;
                    end
                    else if (hdr_ok)
                    begin
                        ident_next  = cand_id;
                        total_next  = cand_total[TOTAL_W-1:0];
                        remain_next = TOTAL_W'({1'b0, cand_len} + 17'd1);
                        fill_next   = '0;
                        q_push      = 1'b1;
                        q_entry.is_header = 1'b1;
                        q_entry.ident     = cand_id;
                        q_entry.total     = cand_total[TOTAL_W-1:0];
                        for (int k = 0; k < HDR_BYTES - 1; k++)
                        begin
                            q_entry.bytes[k] = window_reg[k];
                        end
                        q_entry.bytes[HDR_BYTES-1] = rx.rx_byte;
                    end
                    else
                    begin
                        for (int k = 0; k < HDR_BYTES - 2; k++)
                        begin
                            window_next[k] = window_reg[k+1];
                        end
                        window_next[HDR_BYTES-2] = rx.rx_byte;
                        if (dropped_reg != '1)
                        begin
                            dropped_next = dropped_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_HUNT;
            fill_reg    <= '0;
            remain_reg  <= '0;
            dropped_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            fill_reg    <= fill_next;
            remain_reg  <= remain_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        ident_reg  <= ident_next;
        total_reg  <= total_next;
    end

endmodule

[sv/sprd_queue.sv]
// ============================================================================
// sprd_queue: entry queue between classification and emission
// A small first-in first-out store that lets a six-byte header burst drain
// while further link bytes are still taken in.
// ============================================================================
module sprd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sprd_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output sprd_pkg::queue_entry_t  head_entry,
    output sprd_pkg::queue_status_t status
);
    import sprd_pkg::*;

    queue_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_entry   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/sprd_back.sv]
// ============================================================================
// sprd_back: packet byte emission
// Takes queue entries, spreads each header entry over six output beats and
// drives the registered transmit channel.
// ============================================================================
module sprd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sprd_pkg::queue_entry_t  head_entry,
    input  sprd_pkg::queue_status_t q_status,
    output logic                    q_pop,
    sprd_out_if.source              tx
);
    import sprd_pkg::*;

    queue_entry_t       hold_reg, hold_next;
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic               valid_reg, valid_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               first_reg, first_next;
    logic               last_reg, last_next;
    logic [IDENT_W-1:0] ident_reg, ident_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [DROP_W-1:0]  dropped_reg, dropped_next;
    logic               load;

    assign load = !valid_reg || tx.ready;

    always_comb
    begin
        hold_next    = hold_reg;
        hcnt_next    = hcnt_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        ident_next   = ident_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        q_pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b0;
            if (hcnt_reg != '0)
            begin
                valid_next   = 1'b1;
                byte_next    = hold_reg.bytes[hcnt_reg];
                first_next   = 1'b0;
                last_next    = 1'b0;
                ident_next   = hold_reg.ident;
                total_next   = hold_reg.total;
                dropped_next = hold_reg.dropped;
                hcnt_next    = (hcnt_reg == HCNT_W'(HDR_BYTES - 1)) ? '0 : hcnt_reg + 1'b1;
            end
            else if (!q_status.empty)
            begin
                q_pop        = 1'b1;
                valid_next   = 1'b1;
                byte_next    = head_entry.bytes[0];
                first_next   = head_entry.is_header;
                last_next    = head_entry.last;
                ident_next   = head_entry.ident;
                total_next   = head_entry.total;
                dropped_next = head_entry.dropped;
                if (head_entry.is_header)
                begin
                    hold_next = head_entry;
                    hcnt_next = HCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            hcnt_reg  <= hcnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        byte_reg    <= byte_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        ident_reg   <= ident_next;
        total_reg   <= total_next;
        dropped_reg <= dropped_next;
    end

    assign tx.valid        = valid_reg;
    assign tx.out_byte     = byte_reg;
    assign tx.first_flag   = first_reg;
    assign tx.last_flag    = last_reg;
    assign tx.packet_ident = ident_reg;
    assign tx.packet_total = total_reg;
    assign tx.resync_total = dropped_reg;

endmodule

[sv/space_packet_resync_deframer.sv]
// ============================================================================
// space_packet_resync_deframer: space packet header hunter and deframer
// Finds six-byte packet headers in a raw byte stream and forwards packets.
// ============================================================================
// The rx channel takes one raw link byte per beat, at most one per cycle.
// The tx channel gives one packet byte per beat: six header bytes, the first
// marked by first_flag, then length+1 payload bytes, the final one marked by
// last_flag, each with the packet identifier, total length and drop count.
// Five registers are written through cfg_we, cfg_index and cfg_wdata: four
// accepted identifiers and the largest plausible total length.
// A payload byte taken on rx is written into the queue and from there into
// the output register that drives tx. The byte completing a header yields
// six beats on consecutive cycles while tx is ready, expanded from a single
// entry of an eight-entry queue, so intake goes on at one byte per cycle
// meanwhile, stalls only when that queue fills and sustains one byte a cycle.
// Reset restores the register defaults, empties the window and the queue,
// clears the drop count and starts hunting. When tx stalls, the output
// register holds its beat, the queue fills and rx.ready then drops.
// ============================================================================
module space_packet_resync_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sprd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sprd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    sprd_in_if.sink                         rx,
    sprd_out_if.source                      tx
);
    import sprd_pkg::*;

    logic          q_push;
    logic          q_pop;
    queue_entry_t  q_entry;
    queue_entry_t  q_head;
    queue_status_t q_status;

    sprd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (rx),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    sprd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .status     (q_status)
    );

    sprd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (q_head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .tx         (tx)
    );

endmodule
